// ===== rtl/pbl_pkg.sv =====
// Shared operation codes and Y/V/U field constants for the pixel blend and light unit.
package pbl_pkg;

    typedef enum logic [2:0] {
        OP_EVEN         = 3'd0,
        OP_THREE_ONE    = 3'd1,
        OP_TWELVE_FOUR  = 3'd2,
        OP_FOURTEEN_TWO = 3'd3,
        OP_RATIO        = 3'd4,
        OP_LIGHT        = 3'd5
    } t_op;

    localparam logic [15:0] MASK_EVEN = 16'hFBDF;
    localparam logic [15:0] MASK_Y    = 16'hFC00;
    localparam logic [15:0] MASK_V    = 16'h03E0;
    localparam logic [15:0] MASK_U    = 16'h001F;
    localparam logic [15:0] RND_Y     = 16'h2000;
    localparam logic [15:0] RND_V     = 16'h0100;
    localparam logic [15:0] RND_U     = 16'h0008;

endpackage

// ===== rtl/pixel_blend_light_unit_655_unit.sv =====
// Top level of the pixel blend and light unit: input register, operation units, result register.
//
// Takes one item on every clock at which start is high; busy never rises, so
// items may follow each other on every cycle. The operands are registered, the
// blend or light result is worked out in one pass of logic and registered
// again, so each result is driven with o_done straight from the result
// registers, in the order the items came. The result is shown for that
// single cycle only and cannot be held back, so the receiver must take it then.
module pixel_blend_light_unit_655_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_pixel_a,
    input  logic [15:0] i_pixel_b,
    input  logic [7:0]  i_ratio,
    input  logic [15:0] i_light,
    output logic        o_done,
    output logic [15:0] o_pixel_out
);
    import pbl_pkg::*;

    logic        r_valid;
    logic [2:0]  r_op;
    logic [15:0] r_pixel_a;
    logic [15:0] r_pixel_b;
    logic [7:0]  r_ratio;
    logic [15:0] r_light;
    logic        r_done;
    logic [15:0] r_pixel_out;
    logic [15:0] n_pixel_out;
    logic [15:0] blend_pixel;
    logic [15:0] light_pixel;
    t_op         op;

    assign busy = 1'b0;
    assign op   = t_op'(r_op);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_valid <= start && !busy;
            r_done  <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op      <= i_operation;
            r_pixel_a <= i_pixel_a;
            r_pixel_b <= i_pixel_b;
            r_ratio   <= i_ratio;
            r_light   <= i_light;
        end
        r_pixel_out <= n_pixel_out;
    end

    pbl_blend u_blend (
        .i_op      (op),
        .i_pixel_a (r_pixel_a),
        .i_pixel_b (r_pixel_b),
        .i_ratio   (r_ratio),
        .o_pixel   (blend_pixel)
    );

    pbl_light u_light (
        .i_pixel (r_pixel_a),
        .i_light (r_light),
        .o_pixel (light_pixel)
    );

    // Codes past the light scale have no operation and give a zero pixel.
    always_comb begin
        case (op) inside
            OP_EVEN, OP_THREE_ONE, OP_TWELVE_FOUR, OP_FOURTEEN_TWO, OP_RATIO: begin
                n_pixel_out = blend_pixel;
            end
            OP_LIGHT: n_pixel_out = light_pixel;
            default:  n_pixel_out = 16'h0000;
        endcase
    end

    assign o_done      = r_done;
    assign o_pixel_out = r_pixel_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("accepted item did not produce a result two cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 2))
        else $error("result strobe without an accepted item");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_op > 3'(OP_LIGHT)) |=> (o_pixel_out == 16'h0000))
        else $error("unused operation code gave a nonzero pixel");

endmodule

// ===== rtl/pbl_blend.sv =====
// Two-pixel blends: even average, three-to-one and the weighted per-channel blends.
module pbl_blend (
    input  pbl_pkg::t_op i_op,
    input  logic [15:0]  i_pixel_a,
    input  logic [15:0]  i_pixel_b,
    input  logic [7:0]   i_ratio,
    output logic [15:0]  o_pixel
);
    import pbl_pkg::*;

    logic [16:0] sum_ab;
    logic [15:0] avg_ab;
    logic [16:0] sum_three;
    logic [15:0] avg_three;
    logic [7:0]  wa;
    logic [7:0]  wb;
    logic        use_shift8;
    logic [24:0] acc_y;
    logic [24:0] acc_v;
    logic [24:0] acc_u;
    logic [15:0] sh_y;
    logic [15:0] sh_v;
    logic [15:0] sh_u;
    logic [15:0] weighted;

    assign sum_ab    = {1'b0, i_pixel_a & MASK_EVEN} + {1'b0, i_pixel_b & MASK_EVEN};
    assign avg_ab    = sum_ab[16:1];
    assign sum_three = {1'b0, i_pixel_a & MASK_EVEN} + {1'b0, avg_ab & MASK_EVEN};
    assign avg_three = sum_three[16:1];

    always_comb begin
        case (i_op)
            OP_TWELVE_FOUR: begin
                wa         = 8'd12;
                wb         = 8'd4;
                use_shift8 = 1'b0;
            end
            OP_FOURTEEN_TWO: begin
                wa         = 8'd14;
                wb         = 8'd2;
                use_shift8 = 1'b0;
            end
            default: begin
                wa         = 8'd255 - i_ratio;
                wb         = i_ratio;
                use_shift8 = 1'b1;
            end
        endcase
    end

    // One multiplier pair per channel serves all three weighted blends.
    assign acc_y = 25'(i_pixel_a & MASK_Y) * 25'(wa) + 25'(i_pixel_b & MASK_Y) * 25'(wb)
                 + 25'(RND_Y);
    assign acc_v = 25'(i_pixel_a & MASK_V) * 25'(wa) + 25'(i_pixel_b & MASK_V) * 25'(wb)
                 + 25'(RND_V);
    assign acc_u = 25'(i_pixel_a & MASK_U) * 25'(wa) + 25'(i_pixel_b & MASK_U) * 25'(wb)
                 + 25'(RND_U);

    assign sh_y = use_shift8 ? acc_y[23:8] : acc_y[19:4];
    assign sh_v = use_shift8 ? acc_v[23:8] : acc_v[19:4];
    assign sh_u = use_shift8 ? acc_u[23:8] : acc_u[19:4];

    assign weighted = (sh_y & MASK_Y) | (sh_v & MASK_V) | (sh_u & MASK_U);

    always_comb begin
        case (i_op)
            OP_EVEN:      o_pixel = avg_ab;
            OP_THREE_ONE: o_pixel = avg_three;
            default:      o_pixel = weighted;
        endcase
    end

endmodule

// ===== rtl/pbl_light.sv =====
// Light scaling of one pixel with per-channel saturation.
module pbl_light (
    input  logic [15:0] i_pixel,
    input  logic [15:0] i_light,
    output logic [15:0] o_pixel
);
    import pbl_pkg::*;

    logic [11:0]        ten_lvl;
    logic signed [12:0] scale;
    logic [9:0]         scale_y;
    logic [25:0]        prod_y;
    logic [26:0]        sum_y;
    logic [18:0]        q_y;
    logic [15:0]        sat_y;
    logic signed [5:0]  d_u;
    logic signed [18:0] prod_u;
    logic signed [11:0] q_u;
    logic [4:0]         sat_u;
    logic signed [10:0] d_v;
    logic signed [21:0] prod_v;
    logic signed [14:0] q_v;
    logic [9:0]         sat_v;

    // The scale is 640 minus ten times the level in light bits 15:8.
    assign ten_lvl = {1'b0, i_light[15:8], 3'b000} + {3'b000, i_light[15:8], 1'b0};
    assign scale   = 13'sd640 - $signed({1'b0, ten_lvl});
    assign scale_y = scale[12] ? 10'd0 : scale[9:0];

    assign prod_y = 26'(i_pixel & MASK_Y) * 26'(scale_y);
    assign sum_y  = {1'b0, prod_y} + 27'h1FFFF;
    assign q_y    = sum_y[26:8];
    assign sat_y  = (|q_y[18:16]) ? 16'hFFFF : q_y[15:0];

    // Chroma is scaled about its midpoint; dropping the low bits is a floor.
    assign d_u    = $signed({1'b0, i_pixel[4:0]}) - 6'sd16;
    assign prod_u = 19'(d_u) * 19'(scale);
    assign q_u    = 12'($signed(prod_u[18:8])) + 12'sd16;
    always_comb begin
        if (q_u < 12'sd0) begin
            sat_u = 5'd0;
        end else if (q_u > 12'sd31) begin
            sat_u = 5'd31;
        end else begin
            sat_u = q_u[4:0];
        end
    end

    assign d_v    = $signed({1'b0, i_pixel[9:5], 5'b00000}) - 11'sd512;
    assign prod_v = 22'(d_v) * 22'(scale);
    assign q_v    = 15'($signed(prod_v[21:8])) + 15'sd512;
    always_comb begin
        if (q_v < 15'sd0) begin
            sat_v = 10'd0;
        end else if (q_v > 15'sd1023) begin
            sat_v = 10'd1023;
        end else begin
            sat_v = q_v[9:0];
        end
    end

    assign o_pixel = (sat_y & MASK_Y) | ({6'd0, sat_v} & MASK_V) | ({11'd0, sat_u} & MASK_U);

endmodule
